[sv/adr_pkg.sv]
package adr_pkg;

    localparam int MUL_A_W   = 34;
    localparam int MUL_B_W   = 32;
    localparam int MUL_P_W   = MUL_A_W + MUL_B_W + 1;
    localparam int MUL_STEPS = MUL_B_W;
    localparam int ACC_W     = MUL_P_W + 1;

    // 9.81 in Q.16
    localparam logic [MUL_B_W-1:0] GRAV_Q16 = 32'd642908;
    localparam logic [16:0] ALPHA_ONE = 17'd65536;

    localparam logic [16:0] ALPHA_RST = 17'd6554;
    localparam logic [15:0] THRESH_RST = 16'd256;
    localparam logic [15:0] PERIOD_RST = 16'd655;

    localparam logic [1:0] CFG_ALPHA  = 2'd0;
    localparam logic [1:0] CFG_THRESH = 2'd1;
    localparam logic [1:0] CFG_PERIOD = 2'd2;

    typedef enum logic [1:0] {
        MODE_SAMPLE    = 2'd0,
        MODE_BIAS_EST  = 2'd1,
        MODE_BIAS_LOAD = 2'd2,
        MODE_NONE      = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_GO,
        ST_MUL_WAIT,
        ST_MEAN_WAIT,
        ST_OUT
    } state_t;

    typedef enum logic [3:0] {
        OP_AX, OP_AY, OP_FX1, OP_FX2, OP_FY1, OP_FY2,
        OP_MX, OP_MY, OP_TH, OP_VX, OP_PX, OP_VY, OP_PY
    } op_t;

    typedef enum logic [2:0] {
        MS_IDLE,
        MS_SUM,
        MS_LAST,
        MS_SETUP,
        MS_DIV,
        MS_DONE
    } mean_state_t;

    typedef struct packed {
        logic start;
        logic wr_en;
    } mean_ctl_t;

    function automatic logic signed [ACC_W-1:0] rnd16(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] t;
        t = v + ACC_W'(32768);
        return t >>> 16;
    endfunction

    function automatic logic signed [ACC_W-1:0] rnd12(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] t;
        t = v + ACC_W'(2048);
        return t >>> 12;
    endfunction

    function automatic logic [31:0] sat32(input logic signed [ACC_W-1:0] v);
        if (v > 68'sd2147483647) begin
            return 32'h7FFF_FFFF;
        end else if (v < -68'sd2147483648) begin
            return 32'h8000_0000;
        end
        return v[31:0];
    endfunction

    function automatic logic [47:0] sat48(input logic signed [ACC_W-1:0] v);
        if (v > 68'sd140737488355327) begin
            return 48'h7FFF_FFFF_FFFF;
        end else if (v < -68'sd140737488355328) begin
            return 48'h8000_0000_0000;
        end
        return v[47:0];
    endfunction

endpackage

[sv/adr_mul.sv]
module adr_mul (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                start,
    input  logic signed [adr_pkg::MUL_A_W-1:0] a,
    input  logic        [adr_pkg::MUL_B_W-1:0] b,
    output logic                                done,
    output logic signed [adr_pkg::MUL_P_W-1:0] p
);
    import adr_pkg::*;

    localparam int CW = $clog2(MUL_STEPS);
    localparam logic [CW-1:0] LAST = CW'(MUL_STEPS - 1);

    logic signed [MUL_A_W-1:0] a_reg;
    logic signed [MUL_A_W:0]   hi_reg;
    logic        [MUL_B_W-1:0] lo_reg;
    logic        [CW-1:0]      cnt_reg;
    logic                      busy_reg;
    logic                      done_reg;
    logic signed [MUL_A_W:0]   sum;

    // add multiplicand on a set multiplier bit, then shift the pair right
    assign sum = lo_reg[0] ? hi_reg + {a_reg[MUL_A_W-1], a_reg} : hi_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= busy_reg && (cnt_reg == LAST);
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + CW'(1);
                if (cnt_reg == LAST) begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            a_reg  <= a;
            hi_reg <= '0;
            lo_reg <= b;
        end else if (busy_reg) begin
            hi_reg <= {sum[MUL_A_W], sum[MUL_A_W:1]};
            lo_reg <= {sum[0], lo_reg[MUL_B_W-1:1]};
        end
    end

    assign done = done_reg;
    assign p    = {hi_reg, lo_reg};

endmodule

[sv/adr_mean.sv]
module adr_mean #(
    parameter int HIST_LEN = 64
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  adr_pkg::mean_ctl_t ctl,
    input  logic [31:0]       wr_x,
    input  logic [31:0]       wr_y,
    output logic              done,
    output logic [31:0]       mean_x,
    output logic [31:0]       mean_y
);
    import adr_pkg::*;

    localparam int AW = $clog2(HIST_LEN);
    localparam int SW = 33 + AW;
    localparam int CW = $clog2(SW);
    localparam logic [AW-1:0] LAST_IDX = AW'(HIST_LEN - 1);
    localparam logic [AW:0]   DIVISOR  = (AW + 1)'(HIST_LEN);
    localparam logic [CW-1:0] LAST_BIT = CW'(SW - 1);

    logic [31:0] mem_x [HIST_LEN];
    logic [31:0] mem_y [HIST_LEN];

    mean_state_t state_reg, state_next;
    logic [AW-1:0] slot_reg;
    logic [AW:0]   fill_reg;
    logic [AW-1:0] idx_reg, idx_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          rd_vld_reg, rd_use_reg;
    logic [31:0]   rd_reg [2];

    logic signed [SW-1:0] sum_reg [2];
    logic signed [SW-1:0] sum_next [2];
    logic [SW-1:0]        q_reg [2];
    logic [SW-1:0]        q_next [2];
    logic [AW-1:0]        rem_reg [2];
    logic [AW-1:0]        rem_next [2];
    logic                 neg_reg [2];
    logic                 neg_next [2];
    logic [AW:0]          trial [2];
    logic                 ge [2];

    // history store; only entries below the fill count enter the sum
    always_ff @(posedge aclk) begin
        if (ctl.wr_en) begin
            mem_x[slot_reg] <= wr_x;
            mem_y[slot_reg] <= wr_y;
        end
        rd_reg[0] <= mem_x[idx_reg];
        rd_reg[1] <= mem_y[idx_reg];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slot_reg   <= '0;
            fill_reg   <= '0;
            state_reg  <= MS_IDLE;
            rd_vld_reg <= 1'b0;
        end else begin
            if (ctl.wr_en) begin
                slot_reg <= (slot_reg == LAST_IDX) ? '0 : slot_reg + AW'(1);
                if (fill_reg != DIVISOR) begin
                    fill_reg <= fill_reg + (AW + 1)'(1);
                end
            end
            state_reg  <= state_next;
            rd_vld_reg <= (state_reg == MS_SUM);
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg    <= idx_next;
        cnt_reg    <= cnt_next;
        rd_use_reg <= ({1'b0, idx_reg} < fill_reg);
        sum_reg    <= sum_next;
        q_reg      <= q_next;
        rem_reg    <= rem_next;
        neg_reg    <= neg_next;
    end

    always_comb begin
        for (int l = 0; l < 2; l++) begin
            trial[l] = {rem_reg[l], q_reg[l][SW-1]};
            ge[l]    = (trial[l] >= DIVISOR);
        end
    end

    always_comb begin
        state_next = state_reg;
        idx_next   = idx_reg;
        cnt_next   = cnt_reg;
        sum_next   = sum_reg;
        q_next     = q_reg;
        rem_next   = rem_reg;
        neg_next   = neg_reg;
        done       = 1'b0;

        if (rd_vld_reg && rd_use_reg) begin
            for (int l = 0; l < 2; l++) begin
                sum_next[l] = sum_reg[l] + SW'(signed'(rd_reg[l]));
            end
        end

        unique case (state_reg)
            MS_IDLE: begin
                if (ctl.start) begin
                    idx_next   = '0;
                    sum_next   = '{default: '0};
                    state_next = MS_SUM;
                end
            end
            MS_SUM: begin
                idx_next = idx_reg + AW'(1);
                if (idx_reg == LAST_IDX) begin
                    state_next = MS_LAST;
                end
            end
            MS_LAST: begin
                state_next = MS_SETUP;
            end
            MS_SETUP: begin
                for (int l = 0; l < 2; l++) begin
                    neg_next[l] = sum_reg[l][SW-1];
                    q_next[l]   = sum_reg[l][SW-1] ? SW'(-sum_reg[l]) : SW'(sum_reg[l]);
                    rem_next[l] = '0;
                end
                cnt_next   = '0;
                state_next = MS_DIV;
            end
            MS_DIV: begin
                // one quotient bit per cycle, restoring
                for (int l = 0; l < 2; l++) begin
                    rem_next[l] = ge[l] ? AW'(trial[l] - DIVISOR) : AW'(trial[l]);
                    q_next[l]   = {q_reg[l][SW-2:0], ge[l]};
                end
                cnt_next = cnt_reg + CW'(1);
                if (cnt_reg == LAST_BIT) begin
                    state_next = MS_DONE;
                end
            end
            MS_DONE: begin
                done       = 1'b1;
                state_next = MS_IDLE;
            end
            default: state_next = MS_IDLE;
        endcase
    end

    assign mean_x = neg_reg[0] ? 32'(-q_reg[0]) : q_reg[0][31:0];
    assign mean_y = neg_reg[1] ? 32'(-q_reg[1]) : q_reg[1][31:0];

endmodule

[sv/accel_dead_reckoning.sv]
// Mode 0 runs nine serial multiplies at rest and thirteen in motion; mode 1 walks
// the history and runs the serial divider; mode 2 loads the bias, and modes 2 and 3 go straight to the output.
// Throughput: one transaction at a time; the 32-step shift-add multiplier sets the
// sample rate, the history walk and the serial divider set the bias estimate.
// Reset: synchronous active-low aresetn clears the sequencer, filter, motion, bias
// and output-valid registers and loads register defaults.
module accel_dead_reckoning #(
    parameter int HIST_LEN = 64
) (
    input  logic         aclk,
    input  logic         aresetn,

    input  logic         cfg_we,
    input  logic [1:0]   cfg_index,
    input  logic [16:0]  cfg_wdata,

    input  logic         s_tvalid,
    output logic         s_tready,
    // sample_x[15:0], sample_y[31:16], new_bias_x[63:32], new_bias_y[95:64]
    input  logic [95:0]  s_tdata,
    // mode[1:0]
    input  logic [1:0]   s_tuser,

    output logic         m_tvalid,
    input  logic         m_tready,
    // accel_x[31:0], accel_y[63:32], vel_x[95:64], vel_y[127:96],
    // pos_x[175:128], pos_y[223:176], bias_x[255:224], bias_y[287:256]
    output logic [287:0] m_tdata,
    // moving[0]
    output logic [0:0]   m_tuser
);
    import adr_pkg::*;

    // configuration
    logic [16:0] alpha_reg;
    logic [15:0] thresh_reg;
    logic [15:0] period_reg;
    logic [16:0] alpha_c;
    logic [16:0] alpha_inv;

    // control
    state_t state_reg, state_next;
    op_t    op_reg, op_next;

    // estimator state
    logic [31:0] fx_reg, fx_next, fy_reg, fy_next;
    logic [31:0] vx_reg, vx_next, vy_reg, vy_next;
    logic [47:0] px_reg, px_next, py_reg, py_next;
    logic [31:0] bx_reg, bx_next, by_reg, by_next;
    logic [31:0] ax_reg, ax_next, ay_reg, ay_next;
    logic        moving_reg, moving_next;
    logic [15:0] sx_reg, sy_reg;
    logic signed [ACC_W-1:0] acc_reg, acc_next;

    // output register
    logic         m_valid_reg;
    logic [287:0] m_data_reg;
    logic         m_user_reg;

    // shared multiplier
    logic                      mul_start;
    logic signed [MUL_A_W-1:0] mul_a;
    logic        [MUL_B_W-1:0] mul_b;
    logic                      mul_done;
    logic signed [MUL_P_W-1:0] mul_p;
    logic signed [ACC_W-1:0]   prod;
    logic signed [ACC_W-1:0]   prod_r12;

    // history and mean
    mean_ctl_t   mean_ctl;
    logic        mean_done;
    logic [31:0] mean_x, mean_y;
    logic [31:0] ay_new;

    logic        s_hs;
    logic [32:0] fx_abs, fy_abs;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_hs     = s_tvalid && s_tready;

    // alpha above one acts as one
    assign alpha_c   = (alpha_reg > ALPHA_ONE) ? ALPHA_ONE : alpha_reg;
    assign alpha_inv = ALPHA_ONE - alpha_c;

    assign fx_abs = fx_reg[31] ? 33'(-{fx_reg[31], fx_reg}) : {1'b0, fx_reg};
    assign fy_abs = fy_reg[31] ? 33'(-{fy_reg[31], fy_reg}) : {1'b0, fy_reg};

    assign prod     = ACC_W'(mul_p);
    assign prod_r12 = rnd12(prod);
    assign ay_new   = prod_r12[31:0];

    adr_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .a       (mul_a),
        .b       (mul_b),
        .done    (mul_done),
        .p       (mul_p)
    );

    adr_mean #(
        .HIST_LEN (HIST_LEN)
    ) u_mean (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (mean_ctl),
        .wr_x    (ax_reg),
        .wr_y    (ay_new),
        .done    (mean_done),
        .mean_x  (mean_x),
        .mean_y  (mean_y)
    );

    // configuration writes; an index beyond the list is dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            alpha_reg  <= ALPHA_RST;
            thresh_reg <= THRESH_RST;
            period_reg <= PERIOD_RST;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_ALPHA:  alpha_reg  <= cfg_wdata;
                CFG_THRESH: thresh_reg <= cfg_wdata[15:0];
                CFG_PERIOD: period_reg <= cfg_wdata[15:0];
                default: ;
            endcase
        end
    end

    // multiplier operand select per step
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (op_reg)
            OP_AX: begin
                mul_a = MUL_A_W'(signed'(sx_reg));
                mul_b = GRAV_Q16;
            end
            OP_AY: begin
                mul_a = MUL_A_W'(signed'(sy_reg));
                mul_b = GRAV_Q16;
            end
            OP_FX1: begin
                mul_a = MUL_A_W'(signed'(ax_reg)) - MUL_A_W'(signed'(bx_reg));
                mul_b = MUL_B_W'(alpha_c);
            end
            OP_FX2: begin
                mul_a = MUL_A_W'(signed'(fx_reg));
                mul_b = MUL_B_W'(alpha_inv);
            end
            OP_FY1: begin
                mul_a = MUL_A_W'(signed'(ay_reg)) - MUL_A_W'(signed'(by_reg));
                mul_b = MUL_B_W'(alpha_c);
            end
            OP_FY2: begin
                mul_a = MUL_A_W'(signed'(fy_reg));
                mul_b = MUL_B_W'(alpha_inv);
            end
            OP_MX: begin
                mul_a = MUL_A_W'(fx_abs);
                mul_b = fx_abs[31:0];
            end
            OP_MY: begin
                mul_a = MUL_A_W'(fy_abs);
                mul_b = fy_abs[31:0];
            end
            OP_TH: begin
                mul_a = MUL_A_W'(thresh_reg);
                mul_b = MUL_B_W'(thresh_reg);
            end
            OP_VX: begin
                mul_a = MUL_A_W'(signed'(fx_reg));
                mul_b = MUL_B_W'(period_reg);
            end
            OP_PX: begin
                mul_a = MUL_A_W'(signed'(vx_reg));
                mul_b = MUL_B_W'(period_reg);
            end
            OP_VY: begin
                mul_a = MUL_A_W'(signed'(fy_reg));
                mul_b = MUL_B_W'(period_reg);
            end
            OP_PY: begin
                mul_a = MUL_A_W'(signed'(vy_reg));
                mul_b = MUL_B_W'(period_reg);
            end
            default: ;
        endcase
    end

    // sequencer: next state, step results
    always_comb begin
        state_next  = state_reg;
        op_next     = op_reg;
        fx_next     = fx_reg;
        fy_next     = fy_reg;
        vx_next     = vx_reg;
        vy_next     = vy_reg;
        px_next     = px_reg;
        py_next     = py_reg;
        bx_next     = bx_reg;
        by_next     = by_reg;
        ax_next     = ax_reg;
        ay_next     = ay_reg;
        acc_next    = acc_reg;
        moving_next = moving_reg;
        mul_start   = 1'b0;
        mean_ctl    = '0;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_hs) begin
                    moving_next = 1'b0;
                    unique case (mode_t'(s_tuser))
                        MODE_SAMPLE: begin
                            op_next    = OP_AX;
                            state_next = ST_MUL_GO;
                        end
                        MODE_BIAS_EST: begin
                            mean_ctl.start = 1'b1;
                            state_next     = ST_MEAN_WAIT;
                        end
                        MODE_BIAS_LOAD: begin
                            bx_next    = s_tdata[63:32];
                            by_next    = s_tdata[95:64];
                            state_next = ST_OUT;
                        end
                        default: state_next = ST_OUT;
                    endcase
                end
            end
            ST_MUL_GO: begin
                mul_start  = 1'b1;
                state_next = ST_MUL_WAIT;
            end
            ST_MUL_WAIT: begin
                if (mul_done) begin
                    state_next = ST_MUL_GO;
                    unique case (op_reg)
                        OP_AX: begin
                            ax_next = prod_r12[31:0];
                            op_next = OP_AY;
                        end
                        OP_AY: begin
                            // store the scaled pair in the ring
                            ay_next        = ay_new;
                            mean_ctl.wr_en = 1'b1;
                            op_next        = OP_FX1;
                        end
                        OP_FX1: begin
                            acc_next = prod;
                            op_next  = OP_FX2;
                        end
                        OP_FX2: begin
                            fx_next = sat32(rnd16(acc_reg + prod));
                            op_next = OP_FY1;
                        end
                        OP_FY1: begin
                            acc_next = prod;
                            op_next  = OP_FY2;
                        end
                        OP_FY2: begin
                            fy_next = sat32(rnd16(acc_reg + prod));
                            op_next = OP_MX;
                        end
                        OP_MX: begin
                            acc_next = prod;
                            op_next  = OP_MY;
                        end
                        OP_MY: begin
                            acc_next = acc_reg + prod;
                            op_next  = OP_TH;
                        end
                        OP_TH: begin
                            // compare squared magnitude against squared threshold
                            if (acc_reg > (prod <<< 16)) begin
                                moving_next = 1'b1;
                                op_next     = OP_VX;
                            end else begin
                                vx_next    = '0;
                                vy_next    = '0;
                                state_next = ST_OUT;
                            end
                        end
                        OP_VX: begin
                            vx_next = sat32(ACC_W'(signed'(vx_reg)) + rnd16(prod));
                            op_next = OP_PX;
                        end
                        OP_PX: begin
                            px_next = sat48(ACC_W'(signed'(px_reg)) + rnd16(prod));
                            op_next = OP_VY;
                        end
                        OP_VY: begin
                            vy_next = sat32(ACC_W'(signed'(vy_reg)) + rnd16(prod));
                            op_next = OP_PY;
                        end
                        OP_PY: begin
                            py_next    = sat48(ACC_W'(signed'(py_reg)) + rnd16(prod));
                            state_next = ST_OUT;
                        end
                        default: state_next = ST_OUT;
                    endcase
                end
            end
            ST_MEAN_WAIT: begin
                if (mean_done) begin
                    bx_next    = mean_x;
                    by_next    = mean_y;
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!m_valid_reg || m_tready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            op_reg      <= OP_AX;
            fx_reg      <= '0;
            fy_reg      <= '0;
            vx_reg      <= '0;
            vy_reg      <= '0;
            px_reg      <= '0;
            py_reg      <= '0;
            bx_reg      <= '0;
            by_reg      <= '0;
            moving_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            op_reg     <= op_next;
            fx_reg     <= fx_next;
            fy_reg     <= fy_next;
            vx_reg     <= vx_next;
            vy_reg     <= vy_next;
            px_reg     <= px_next;
            py_reg     <= py_next;
            bx_reg     <= bx_next;
            by_reg     <= by_next;
            moving_reg <= moving_next;
            // hold the result until taken; load a new one when the slot frees
            if (state_reg == ST_OUT && (!m_valid_reg || m_tready)) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        ax_reg  <= ax_next;
        ay_reg  <= ay_next;
        acc_reg <= acc_next;
        if (s_hs) begin
            sx_reg <= s_tdata[15:0];
            sy_reg <= s_tdata[31:16];
        end
        if (state_reg == ST_OUT && (!m_valid_reg || m_tready)) begin
            m_data_reg <= {by_reg, bx_reg, py_reg, px_reg, vy_reg, vx_reg, fy_reg, fx_reg};
            m_user_reg <= moving_reg;
        end
    end

    assign m_tvalid   = m_valid_reg;
    assign m_tdata    = m_data_reg;
    assign m_tuser[0] = m_user_reg;

    a_mul_done_in_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        mul_done |-> state_reg == ST_MUL_WAIT)
        else $error("multiplier finished outside its wait step");

    a_mean_done_in_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        mean_done |-> state_reg == ST_MEAN_WAIT)
        else $error("mean finished outside its wait step");

    a_accept_leaves_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_hs |=> !s_tready)
        else $error("input taken while an item is still in progress");

    a_out_loads: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_OUT && (!m_valid_reg || m_tready)) |=> m_valid_reg)
        else $error("finished result not presented");

endmodule

[sim/accel_dead_reckoning_test.sv]
module accel_dead_reckoning_test;
    import adr_pkg::*;

    localparam int HIST = 64;
    localparam longint MAX32 = 64'sd2147483647;
    localparam longint MIN32 = -64'sd2147483648;
    localparam longint MAX48 = 64'sd140737488355327;
    localparam longint MIN48 = -64'sd140737488355328;
    localparam int CYCLE_LIMIT = 4000000;

    // one reported navigation state, as carried on the result channel
    typedef struct packed {
        logic [31:0] bias_y;
        logic [31:0] bias_x;
        logic [47:0] pos_y;
        logic [47:0] pos_x;
        logic [31:0] vel_y;
        logic [31:0] vel_x;
        logic [31:0] accel_y;
        logic [31:0] accel_x;
    } nav_state_t;

    // floor shift right of a signed value
    function automatic longint floor_shr(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint clamp(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    // Tracks the estimator state and holds the states the block must report.
    class nav_tracker;
        longint hist_x[HIST];
        longint hist_y[HIST];
        int slot;
        longint filt_x, filt_y, vel_x, vel_y, pos_x, pos_y, bias_x, bias_y;
        longint alpha, thresh, period;
        nav_state_t pending_state[$];
        bit pending_moving[$];
        int mismatches;

        function void clear();
            for (int i = 0; i < HIST; i++) begin
                hist_x[i] = 0;
                hist_y[i] = 0;
            end
            slot = 0;
            filt_x = 0; filt_y = 0; vel_x = 0; vel_y = 0;
            pos_x = 0; pos_y = 0; bias_x = 0; bias_y = 0;
            alpha = ALPHA_RST; thresh = THRESH_RST; period = PERIOD_RST;
            mismatches = 0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [16:0] val);
            if (idx == CFG_ALPHA) alpha = val;
            else if (idx == CFG_THRESH) thresh = val[15:0];
            else if (idx == CFG_PERIOD) period = val[15:0];
        endfunction

        function longint lowpass(longint s, longint b, longint prev, longint a);
            return clamp(floor_shr(a * (s - b) + (65536 - a) * prev + 32768, 16),
                          MIN32, MAX32);
        endfunction

        // advance the state by one accepted transaction and queue what it reports
        function void note_input(mode_t mode, logic [95:0] data);
            longint sx, sy, ax, ay, a, thr2, sumx, sumy;
            longint unsigned mag2;
            bit mov;
            nav_state_t st;
            mov = 0;
            if (mode == MODE_SAMPLE) begin
                sx = longint'($signed(data[15:0]));
                sy = longint'($signed(data[31:16]));
                ax = floor_shr(sx * 642908 + 2048, 12);
                ay = floor_shr(sy * 642908 + 2048, 12);
                a = alpha > 65536 ? 65536 : alpha;
                hist_x[slot] = ax;
                hist_y[slot] = ay;
                slot = (slot + 1 >= HIST) ? 0 : slot + 1;
                filt_x = lowpass(ax, bias_x, filt_x, a);
                filt_y = lowpass(ay, bias_y, filt_y, a);
                // the sum of two squares can reach 2^63
                mag2 = longint'(unsigned'(filt_x * filt_x)) + longint'(unsigned'(filt_y * filt_y));
                thr2 = (thresh * thresh) <<< 16;
                if (mag2 > longint'(unsigned'(thr2))) begin
                    mov = 1;
                    vel_x = clamp(vel_x + floor_shr(filt_x * period + 32768, 16), MIN32, MAX32);
                    pos_x = clamp(pos_x + floor_shr(vel_x * period + 32768, 16), MIN48, MAX48);
                    vel_y = clamp(vel_y + floor_shr(filt_y * period + 32768, 16), MIN32, MAX32);
                    pos_y = clamp(pos_y + floor_shr(vel_y * period + 32768, 16), MIN48, MAX48);
                end else begin
                    vel_x = 0;
                    vel_y = 0;
                end
            end else if (mode == MODE_BIAS_EST) begin
                sumx = 0;
                sumy = 0;
                for (int i = 0; i < HIST; i++) begin
                    sumx += hist_x[i];
                    sumy += hist_y[i];
                end
                // SV division truncates toward zero, as required
                bias_x = sumx / HIST;
                bias_y = sumy / HIST;
            end else if (mode == MODE_BIAS_LOAD) begin
                bias_x = longint'($signed(data[63:32]));
                bias_y = longint'($signed(data[95:64]));
            end
            st.accel_x = filt_x[31:0];
            st.accel_y = filt_y[31:0];
            st.vel_x = vel_x[31:0];
            st.vel_y = vel_y[31:0];
            st.pos_x = pos_x[47:0];
            st.pos_y = pos_y[47:0];
            st.bias_x = bias_x[31:0];
            st.bias_y = bias_y[31:0];
            pending_state.push_back(st);
            pending_moving.push_back(mov);
        endfunction

        function void check_result(logic [287:0] data, logic moving);
            nav_state_t want;
            bit want_mov;
            nav_state_t got;
            got = data;
            if (pending_state.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %h", data);
                return;
            end
            want = pending_state.pop_front();
            want_mov = pending_moving.pop_front();
            if (got.accel_x !== want.accel_x || got.accel_y !== want.accel_y ||
                got.vel_x !== want.vel_x || got.vel_y !== want.vel_y ||
                got.pos_x !== want.pos_x || got.pos_y !== want.pos_y ||
                got.bias_x !== want.bias_x || got.bias_y !== want.bias_y ||
                moving !== want_mov) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: expected %h moving %0b, actual %h moving %0b",
                             want, want_mov, got, moving);
            end
        endfunction
    endclass

    logic         aclk = 0;
    logic         aresetn = 0;
    logic         cfg_we = 0;
    logic [1:0]   cfg_index = '0;
    logic [16:0]  cfg_wdata = '0;
    logic         s_tvalid = 0;
    logic         s_tready;
    logic [95:0]  s_tdata = '0;
    logic [1:0]   s_tuser = '0;
    logic         m_tvalid;
    logic         m_tready = 0;
    logic [287:0] m_tdata;
    logic [0:0]   m_tuser;

    nav_tracker tracker;
    int send_idle_pct = 22;
    int recv_idle_pct = 45;
    int cycle_count = 0;

    accel_dead_reckoning u_dut (.*);

    always #6 aclk = ~aclk;

    // hold the run within a bounded cycle budget
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // receiver: stall at random, check each accepted transaction
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) tracker.check_result(m_tdata, m_tuser[0]);
        m_tready <= aresetn && ($urandom_range(99) >= recv_idle_pct);
    end

    task automatic write_reg(logic [1:0] idx, logic [16:0] val);
        cfg_we <= 1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we <= 0;
        tracker.set_reg(idx, val);
        @(posedge aclk);
    endtask

    // drive one transaction, idling before it at random; valid stays up after
    // the handshake until the next idle cycle or the drain
    task automatic send(mode_t mode, logic [15:0] sx, logic [15:0] sy,
                        logic [31:0] bx, logic [31:0] by);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 0;
            @(posedge aclk);
        end
        s_tvalid <= 1;
        s_tuser <= mode;
        s_tdata <= {by, bx, sy, sx};
        do @(posedge aclk); while (!s_tready);
        tracker.note_input(mode, {by, bx, sy, sx});
    endtask

    task automatic send_random();
        int r;
        logic [15:0] sx, sy;
        r = $urandom_range(99);
        // mostly modest motion so the integrators move; some full-range samples
        if (r < 55) begin
            sx = 16'($signed($urandom_range(8000)) - 4000);
            sy = 16'($signed($urandom_range(8000)) - 4000);
            send(MODE_SAMPLE, sx, sy, $urandom, $urandom);
        end else if (r < 75) begin
            send(MODE_SAMPLE, 16'($urandom), 16'($urandom), $urandom, $urandom);
        end else if (r < 85) begin
            send(MODE_SAMPLE, 16'($urandom_range(3) - 1), 16'($urandom_range(3) - 1),
                 $urandom, $urandom);
        end else if (r < 91) begin
            send(MODE_BIAS_EST, 16'($urandom), 16'($urandom), $urandom, $urandom);
        end else if (r < 97) begin
            if ($urandom_range(1))
                send(MODE_BIAS_LOAD, 16'($urandom), 16'($urandom), $urandom, $urandom);
            else
                send(MODE_BIAS_LOAD, 16'($urandom), 16'($urandom),
                     32'($signed($urandom_range(400000)) - 200000),
                     32'($signed($urandom_range(400000)) - 200000));
        end else begin
            send(MODE_NONE, 16'($urandom), 16'($urandom), $urandom, $urandom);
        end
    endtask

    // drop valid, wait for every expected result, then let the block settle
    task automatic drain();
        s_tvalid <= 0;
        while (tracker.pending_state.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic random_config();
        write_reg(CFG_ALPHA, $urandom_range(1) ? 17'($urandom_range(131071))
                                               : 17'($urandom_range(65536)));
        write_reg(CFG_THRESH, $urandom_range(3) == 0 ? 16'($urandom)
                                                     : 16'($urandom_range(1024)));
        write_reg(CFG_PERIOD, $urandom_range(3) == 0 ? 16'($urandom)
                                                     : 16'($urandom_range(4000)));
    endtask

    initial begin
        tracker = new();
        tracker.clear();
        repeat (6) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // directed: bias estimate on the cleared history, extremes, every mode
        send(MODE_BIAS_EST, 0, 0, 0, 0);
        send(MODE_SAMPLE, 16'h7FFF, 16'h8000, 0, 0);
        send(MODE_SAMPLE, 16'h8000, 16'h7FFF, 0, 0);
        send(MODE_SAMPLE, 16'hFFFF, 16'h0001, 0, 0);
        send(MODE_SAMPLE, 0, 0, 0, 0);
        send(MODE_BIAS_LOAD, 16'hFFFF, 16'hFFFF, 32'h7FFF_FFFF, 32'h8000_0000);
        send(MODE_SAMPLE, 16'h1000, 16'hF000, 0, 0);
        send(MODE_NONE, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send(MODE_BIAS_LOAD, 0, 0, 0, 0);
        send(MODE_BIAS_EST, 0, 0, 0, 0);
        drain();
        // alpha above one, zero threshold, largest period: drive saturation
        write_reg(CFG_ALPHA, 17'h1FFFF);
        write_reg(CFG_THRESH, 16'd0);
        write_reg(CFG_PERIOD, 16'hFFFF);
        repeat (6) send(MODE_SAMPLE, 16'h7FFF, 16'h8000, 0, 0);
        send(MODE_SAMPLE, 0, 0, 0, 0);
        drain();
        // zero period and the largest threshold: no motion
        write_reg(CFG_ALPHA, 17'd0);
        write_reg(CFG_THRESH, 16'hFFFF);
        write_reg(CFG_PERIOD, 16'd0);
        send(MODE_SAMPLE, 16'h7FFF, 16'h7FFF, 0, 0);
        drain();
        write_reg(CFG_ALPHA, ALPHA_ONE);
        write_reg(CFG_THRESH, 16'd0);
        send(MODE_SAMPLE, 16'h7FFF, 16'h7FFF, 0, 0);
        send(MODE_SAMPLE, 16'h4000, 16'h4000, 0, 0);
        drain();

        // random phases with a new register setting for each
        for (int ph = 0; ph < 16; ph++) begin
            if (ph == 6) begin
                send_idle_pct = 45;
                recv_idle_pct = 22;
            end else if (ph == 11) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            random_config();
            repeat (100) send_random();
            drain();
        end

        repeat (50) @(posedge aclk);
        if (tracker.mismatches == 0 && tracker.pending_state.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule

[filelist.f]
sv/adr_pkg.sv
sv/adr_mul.sv
sv/adr_mean.sv
sv/accel_dead_reckoning.sv
sim/accel_dead_reckoning_test.sv
